// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL; only vgm_engine.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define VGM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define VGM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/vgm_pkg.sv -----
// Types and constants of the voxel greedy mesher.
package vgm_pkg;

    localparam int SIDE      = 16;
    localparam int COORD_W   = 4;
    localparam int SLICE_N   = 256;
    localparam int SLICE_AW  = 8;
    localparam int VOX_DEPTH = 4096;
    localparam int VOX_AW    = 12;
    localparam int COLOR_W   = 8;
    localparam int EXT_W     = 5;
    localparam int ORIGIN_W  = 21;
    localparam int CORNER_W  = 22;
    localparam int MODE_W    = 2;
    localparam int AXIS_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FETCH   = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic               quad;
        logic [AXIS_W-1:0]  axis;
        logic               neg;
        logic [EXT_W-1:0]   px;
        logic [EXT_W-1:0]   py;
        logic [EXT_W-1:0]   pz;
        logic [EXT_W-1:0]   w;
        logic [EXT_W-1:0]   h;
        logic [COLOR_W-1:0] color;
    } quad_t;

endpackage

// ----- rtl/vgm_if.sv -----
// Valid/ready channel interfaces for input and result words.
interface vgm_in_if;
    logic                          valid;
    logic                          ready;
    logic [vgm_pkg::MODE_W-1:0]    mode;
    logic [vgm_pkg::COORD_W-1:0]   voxel_x;
    logic [vgm_pkg::COORD_W-1:0]   voxel_y;
    logic [vgm_pkg::COORD_W-1:0]   voxel_z;
    logic [vgm_pkg::COLOR_W-1:0]   voxel_color;

    modport source (output valid, mode, voxel_x, voxel_y, voxel_z, voxel_color,
                    input ready);
    modport sink (input valid, mode, voxel_x, voxel_y, voxel_z, voxel_color,
                  output ready);
endinterface

interface vgm_out_if;
    logic                                valid;
    logic                                ready;
    logic                                quad_valid;
    logic                                scan_done;
    logic [vgm_pkg::AXIS_W-1:0]          face_axis;
    logic                                face_negative;
    logic signed [vgm_pkg::CORNER_W-1:0] corner_x;
    logic signed [vgm_pkg::CORNER_W-1:0] corner_y;
    logic signed [vgm_pkg::CORNER_W-1:0] corner_z;
    logic [vgm_pkg::EXT_W-1:0]           quad_width;
    logic [vgm_pkg::EXT_W-1:0]           quad_height;
    logic [vgm_pkg::COLOR_W-1:0]         quad_color;

    modport source (output valid, quad_valid, scan_done, face_axis, face_negative,
                    corner_x, corner_y, corner_z, quad_width, quad_height, quad_color,
                    input ready);
    modport sink (input valid, quad_valid, scan_done, face_axis, face_negative,
                  corner_x, corner_y, corner_z, quad_width, quad_height, quad_color,
                  output ready);
endinterface

// ----- rtl/voxel_greedy_mesher.sv -----
// Top level of the voxel greedy mesher: origin registers and result register.
//
// The block holds a 16x16x16 chunk of 8-bit colors (0 is air) and hands out greedy-merged
// quads of visible faces one per fetch word. After reset a clearing pass writes the whole
// voxel memory, during which no input word is taken; origin writes are taken at any time
// and are applied to the corners as the result word leaves, so they should change only
// while no fetch is outstanding. Write and restart words are handled in the idle state.
// A fetch runs a sequencer over the voxel memory and the slice memory: building a slice
// passes the states BP, BN and BW for each face slot, searching passes SEARCH and SCHK
// for each slot, merging passes WIDTH and WCHK for each column tried for the width and
// HEIGHT and HCHK for each cell checked for the height, and clearing the merged faces
// writes one cell at a time. A fetch may pass every slice left in a scan. The next input
// word is taken once the result has moved into the output register, where it sits until
// taken.
module voxel_greedy_mesher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [vgm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [vgm_pkg::ORIGIN_W-1:0]    wr_data,
    vgm_in_if.sink                          in_ch,
    vgm_out_if.source                       out_ch
);

    import vgm_pkg::*;

    logic [ORIGIN_W-1:0] org_x_reg, org_y_reg, org_z_reg;
    logic                out_valid_reg;
    quad_t               out_reg;
    cmd_t                cmd;
    quad_t               res;
    logic                res_valid, res_take;

    assign cmd = '{mode: in_ch.mode, x: in_ch.voxel_x, y: in_ch.voxel_y,
                   z: in_ch.voxel_z, color: in_ch.voxel_color};

    vgm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (in_ch.valid),
        .cmd       (cmd),
        .cmd_ready (in_ch.ready),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    assign res_take = res_valid && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            org_z_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_index == CFG_ORIGIN_X)
            begin
                org_x_reg <= wr_data;
            end
            if (wr_en && wr_index == CFG_ORIGIN_Y)
            begin
                org_y_reg <= wr_data;
            end
            if (wr_en && wr_index == CFG_ORIGIN_Z)
            begin
                org_z_reg <= wr_data;
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    // Corners are zero in a done word.
    function automatic logic [CORNER_W-1:0] corner(input logic [ORIGIN_W-1:0] org,
                                                   input logic [EXT_W-1:0] p,
                                                   input logic quad);
        logic [CORNER_W-1:0] s;
        s = {org[ORIGIN_W-1], org} + {{(CORNER_W - EXT_W){1'b0}}, p};
        return quad ? s : '0;
    endfunction

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.quad_valid    = out_reg.quad;
    assign out_ch.scan_done     = !out_reg.quad;
    assign out_ch.face_axis     = out_reg.axis;
    assign out_ch.face_negative = out_reg.neg;
    assign out_ch.corner_x      = corner(org_x_reg, out_reg.px, out_reg.quad);
    assign out_ch.corner_y      = corner(org_y_reg, out_reg.py, out_reg.quad);
    assign out_ch.corner_z      = corner(org_z_reg, out_reg.pz, out_reg.quad);
    assign out_ch.quad_width    = out_reg.w;
    assign out_ch.quad_height   = out_reg.h;
    assign out_ch.quad_color    = out_reg.color;

endmodule

// ----- rtl/vgm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/vgm_engine.sv -----
// Scan engine: voxel memory, slice work area and the greedy merge sequencer.
`include "assert_macros.svh"

module vgm_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  vgm_pkg::cmd_t cmd,
    output logic          cmd_ready,
    output logic          res_valid,
    output vgm_pkg::quad_t res,
    input  logic          res_take
);

    import vgm_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SEARCH = 4'd2;
    localparam logic [3:0] S_SCHK   = 4'd3;
    localparam logic [3:0] S_WIDTH  = 4'd4;
    localparam logic [3:0] S_WCHK   = 4'd5;
    localparam logic [3:0] S_HEIGHT = 4'd6;
    localparam logic [3:0] S_HCHK   = 4'd7;
    localparam logic [3:0] S_WIPE   = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;
    localparam logic [3:0] S_BP     = 4'd10;
    localparam logic [3:0] S_BN     = 4'd11;
    localparam logic [3:0] S_BW     = 4'd12;

    localparam logic [SLICE_AW:0] PTR_END  = 9'(SLICE_N);
    localparam logic [3:0]        LAST_SLC = 4'(SIDE - 1);
    localparam logic [4:0]        SLC_NONE = 5'h1F;

    logic [3:0]          state_reg, state_next;
    logic [VOX_AW-1:0]   clr_reg, clr_next;
    logic [AXIS_W-1:0]   axis_reg, axis_next;
    logic                neg_reg, neg_next;
    logic [4:0]          slice_reg, slice_next;
    logic                active_reg, active_next;
    logic [SLICE_AW:0]   ptr_reg, ptr_next;
    logic [SLICE_AW-1:0] pos_reg, pos_next;
    logic [SLICE_AW-1:0] base_reg, base_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic [COLOR_W-1:0]  pcol_reg, pcol_next;
    logic [EXT_W-1:0]    w_reg, w_next;
    logic [EXT_W-1:0]    h_reg, h_next;
    logic [EXT_W-1:0]    k_reg, k_next;
    logic [EXT_W-1:0]    l_reg, l_next;
    quad_t               res_reg, res_next;

    logic                vox_we;
    logic [VOX_AW-1:0]   vox_waddr, vox_raddr;
    logic [COLOR_W-1:0]  vox_wdata, vox_rdata;
    logic                slc_we;
    logic [SLICE_AW-1:0] slc_waddr, slc_raddr;
    logic [COLOR_W-1:0]  slc_wdata, slc_rdata;

    logic [3:0] base_i, base_j, nslc;
    logic       nvalid;
    logic [4:0] col_w, row_h, col_k, row_l, sc;
    logic       vis;

    // Maps (axis, slice, u, v) onto the memory address {x, y, z}.
    function automatic logic [VOX_AW-1:0] vox_addr(input logic [AXIS_W-1:0] ax,
                                                  input logic [3:0] s,
                                                  input logic [3:0] i,
                                                  input logic [3:0] j);
        logic [VOX_AW-1:0] a;
        unique case (ax)
            AXIS_X:  a = {s, i, j};
            AXIS_Y:  a = {j, s, i};
            default: a = {i, j, s};
        endcase
        return a;
    endfunction

    vgm_ram #(.WIDTH(COLOR_W), .DEPTH(VOX_DEPTH)) u_vox_ram (
        .clk   (clk),
        .we    (vox_we),
        .waddr (vox_waddr),
        .wdata (vox_wdata),
        .raddr (vox_raddr),
        .rdata (vox_rdata)
    );

    // The slice memory holds the color of every still visible face and zero elsewhere,
    // so a nonzero entry doubles as the visible flag.
    vgm_ram #(.WIDTH(COLOR_W), .DEPTH(SLICE_N)) u_slice_ram (
        .clk   (clk),
        .we    (slc_we),
        .waddr (slc_waddr),
        .wdata (slc_wdata),
        .raddr (slc_raddr),
        .rdata (slc_rdata)
    );

    assign base_i = base_reg[3:0];
    assign base_j = base_reg[7:4];
    assign nslc   = neg_reg ? slice_reg[3:0] - 4'd1 : slice_reg[3:0] + 4'd1;
    assign nvalid = neg_reg ? (slice_reg[3:0] != 4'd0) : (slice_reg[3:0] != LAST_SLC);
    assign col_w  = {1'b0, base_i} + w_reg;
    assign row_h  = {1'b0, base_j} + h_reg;
    assign col_k  = {1'b0, base_i} + k_reg;
    assign row_l  = {1'b0, base_j} + l_reg;
    assign sc     = neg_reg ? slice_reg : slice_reg + 5'd1;
    assign vis    = (pcol_reg != '0) && (!nvalid || vox_rdata == '0);

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        axis_next   = axis_reg;
        neg_next    = neg_reg;
        slice_next  = slice_reg;
        active_next = active_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        base_next   = base_reg;
        color_next  = color_reg;
        pcol_next   = pcol_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        k_next      = k_reg;
        l_next      = l_reg;
        res_next    = res_reg;
        vox_we      = 1'b0;
        vox_waddr   = {cmd.x, cmd.y, cmd.z};
        vox_wdata   = cmd.color;
        vox_raddr   = vox_addr(axis_reg, slice_reg[3:0], pos_reg[3:0], pos_reg[7:4]);
        slc_we      = 1'b0;
        slc_waddr   = pos_reg;
        slc_wdata   = vis ? pcol_reg : '0;
        slc_raddr   = ptr_reg[SLICE_AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                vox_we    = 1'b1;
                vox_waddr = clr_reg;
                vox_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == VOX_AW'(VOX_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.mode == MODE_WRITE)
                    begin
                        vox_we = 1'b1;
                    end
                    else if (cmd.mode == MODE_RESTART)
                    begin
                        // The pointer at its end forces a slice build before any read.
                        axis_next   = AXIS_X;
                        neg_next    = 1'b1;
                        slice_next  = SLC_NONE;
                        active_next = 1'b1;
                        ptr_next    = PTR_END;
                    end
                    else if (cmd.mode == MODE_FETCH)
                    begin
                        if (active_reg)
                        begin
                            state_next = S_SEARCH;
                        end
                        else
                        begin
                            res_next   = '0;
                            state_next = S_RESULT;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (ptr_reg == PTR_END)
                begin
                    // Slice exhausted: step to the next slice or face direction, or end the scan.
                    if (slice_reg[3:0] == LAST_SLC && !slice_reg[4])
                    begin
                        slice_next = SLC_NONE;
                        if (neg_reg)
                        begin
                            neg_next = 1'b0;
                        end
                        else
                        begin
                            neg_next = 1'b1;
                            if (axis_reg == AXIS_Z)
                            begin
                                axis_next   = AXIS_X;
                                active_next = 1'b0;
                                res_next    = '0;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                axis_next = axis_reg + 2'd1;
                            end
                        end
                    end
                    else
                    begin
                        slice_next = slice_reg + 5'd1;
                        pos_next   = '0;
                        state_next = S_BP;
                    end
                end
                else
                begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (slc_rdata != '0)
                begin
                    base_next  = ptr_reg[SLICE_AW-1:0];
                    color_next = slc_rdata;
                    w_next     = 5'd1;
                    state_next = S_WIDTH;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_WIDTH:
            begin
                slc_raddr = {base_j, col_w[3:0]};
                if (!col_w[4])
                begin
                    state_next = S_WCHK;
                end
                else
                begin
                    h_next     = 5'd1;
                    k_next     = '0;
                    state_next = S_HEIGHT;
                end
            end
            S_WCHK:
            begin
                if (slc_rdata == color_reg)
                begin
                    w_next     = w_reg + 5'd1;
                    state_next = S_WIDTH;
                end
                else
                begin
                    h_next     = 5'd1;
                    k_next     = '0;
                    state_next = S_HEIGHT;
                end
            end
            S_HEIGHT:
            begin
                slc_raddr = {row_h[3:0], col_k[3:0]};
                if (row_h[4])
                begin
                    k_next     = '0;
                    l_next     = '0;
                    state_next = S_WIPE;
                end
                else
                begin
                    state_next = S_HCHK;
                end
            end
            S_HCHK:
            begin
                if (slc_rdata != color_reg)
                begin
                    k_next     = '0;
                    l_next     = '0;
                    state_next = S_WIPE;
                end
                else if (k_reg + 5'd1 == w_reg)
                begin
                    h_next     = h_reg + 5'd1;
                    k_next     = '0;
                    state_next = S_HEIGHT;
                end
                else
                begin
                    k_next     = k_reg + 5'd1;
                    state_next = S_HEIGHT;
                end
            end
            S_WIPE:
            begin
                // Clears the merged rectangle one cell a cycle, row by row.
                slc_we    = 1'b1;
                slc_waddr = {row_l[3:0], col_k[3:0]};
                slc_wdata = '0;
                if (k_reg + 5'd1 == w_reg)
                begin
                    k_next = '0;
                    if (l_reg + 5'd1 == h_reg)
                    begin
                        res_next.quad  = 1'b1;
                        res_next.axis  = axis_reg;
                        res_next.neg   = neg_reg;
                        res_next.w     = w_reg;
                        res_next.h     = h_reg;
                        res_next.color = color_reg;
                        unique case (axis_reg)
                            AXIS_X:
                            begin
                                res_next.px = sc;
                                res_next.py = {1'b0, base_i};
                                res_next.pz = {1'b0, base_j};
                            end
                            AXIS_Y:
                            begin
                                res_next.py = sc;
                                res_next.pz = {1'b0, base_i};
                                res_next.px = {1'b0, base_j};
                            end
                            default:
                            begin
                                res_next.pz = sc;
                                res_next.px = {1'b0, base_i};
                                res_next.py = {1'b0, base_j};
                            end
                        endcase
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        l_next = l_reg + 5'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 5'd1;
                end
            end
            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BP:
            begin
                state_next = S_BN;
            end
            S_BN:
            begin
                vox_raddr  = vox_addr(axis_reg, nslc, pos_reg[3:0], pos_reg[7:4]);
                pcol_next  = vox_rdata;
                state_next = S_BW;
            end
            S_BW:
            begin
                slc_we   = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == SLICE_AW'(SLICE_N - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_SEARCH;
                end
                else
                begin
                    state_next = S_BP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            axis_reg   <= AXIS_X;
            neg_reg    <= 1'b1;
            slice_reg  <= SLC_NONE;
            active_reg <= 1'b0;
            ptr_reg    <= PTR_END;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            axis_reg   <= axis_next;
            neg_reg    <= neg_next;
            slice_reg  <= slice_next;
            active_reg <= active_next;
            ptr_reg    <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        base_reg  <= base_next;
        color_reg <= color_next;
        pcol_reg  <= pcol_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        k_reg     <= k_next;
        l_reg     <= l_next;
        res_reg   <= res_next;
    end

    `VGM_ASSERT_NEXT(a_restart_arms_scan,
        cmd_valid && cmd_ready && cmd.mode == MODE_RESTART, active_reg && ptr_reg == PTR_END)
    `VGM_ASSERT_IMPL(a_quad_has_extent,
        res_valid && res_reg.quad, res_reg.w != '0 && res_reg.h != '0)
    `VGM_ASSERT_IMPL(a_quad_while_active, res_valid && res_reg.quad, active_reg)

endmodule
